@@ rtl/lpsg_pkg.sv @@
// Shared constants, widths and the arctangent table for the polar stereographic grid mapper.
// No dependencies; imported by lpsg_cordic, lpsg_div, the top level and the testbench.
package lpsg_pkg;

   localparam int ANGLE_FRAC_BITS  = 16;
   localparam int COORD_FRAC_BITS  = 10;
   localparam int CORDIC_STEPS_DEF = 24;

   localparam int LON_W = 25;
   localparam int LAT_W = 24;
   localparam int ANG_W = 26;              // longitude minus reference meridian
   localparam int RED_W = 25;              // angle wrapped into [-180, 180)

   localparam longint unsigned FULL_TURN    = 64'd360 << ANGLE_FRAC_BITS;
   localparam longint unsigned HALF_TURN    = 64'd180 << ANGLE_FRAC_BITS;
   localparam longint unsigned QUARTER_TURN = 64'd90 << ANGLE_FRAC_BITS;
   localparam int MAG_W  = $clog2(QUARTER_TURN + 1);
   localparam int HALF_W = $clog2(HALF_TURN + 1);

   localparam logic signed [ANG_W-1:0] REF_MERIDIAN = ANG_W'(64'd10 << ANGLE_FRAC_BITS);

   // degrees to radians Q30: estimate by reciprocal, then one correction
   localparam longint unsigned PI_Q30   = 64'd3373259426;
   localparam int              RECIP_SH = 23;
   localparam longint unsigned RECIP    = ((PI_Q30 << RECIP_SH) / HALF_TURN) + 64'd1;
   localparam int              QE_W     = 32;

   localparam int XY_W = 32;
   localparam int Z_W  = 34;
   localparam longint GAIN_Q30 = 64'd652032874;

   // ratio stage
   localparam int RATIO_FRAC = 30;
   localparam int NUM_W      = 33;
   localparam int DEN_W      = 32;
   localparam int QB         = 34;         // quotient bits kept
   localparam int Q_W        = QB + 1;
   localparam longint unsigned RATIO_LIM = 64'd1 << 33;

   localparam longint unsigned SCALE_Q16 = 64'd779003918;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_GRID_COLS  = 3'd0,
      CSR_GRID_ROWS  = 3'd1,
      CSR_OFFSET_COL = 3'd2,
      CSR_OFFSET_ROW = 3'd3,
      CSR_ORIGIN_X   = 3'd4,
      CSR_ORIGIN_Y   = 3'd5
   } csr_index_type;

   function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         0:  v = Z_W'(843314857);
         1:  v = Z_W'(497837829);
         2:  v = Z_W'(263043837);
         3:  v = Z_W'(133525159);
         4:  v = Z_W'(67021687);
         5:  v = Z_W'(33543516);
         6:  v = Z_W'(16775851);
         7:  v = Z_W'(8388437);
         8:  v = Z_W'(4194283);
         9:  v = Z_W'(2097149);
         default: begin
            // arctangent equals its argument to within half an LSB here
            if (idx < 30) v = Z_W'(64'd1 << (30 - idx));
            else          v = Z_W'(1);
         end
      endcase
      return v;
   endfunction

endpackage

@@ rtl/latlon_to_polar_stereo_grid_top.sv @@
// Polar stereographic grid mapper: longitude/latitude to 1 km grid column, row, inside flag.
// Throughput one item per cycle; the whole pipeline holds while a result waits under stall.
// Reset clears all valid bits and returns the grid registers to 900x900, offsets 450/450.
// Depends on lpsg_pkg, lpsg_cordic and lpsg_div.
module latlon_to_polar_stereo_grid_top
   import lpsg_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [LON_W-1:0] req_longitude,
   input  logic signed [LAT_W-1:0] req_latitude,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [15:0]      rsp_col,
   output logic signed [15:0]      rsp_row,
   output logic                    rsp_inside_res,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [23:0]             csr_wdata
);

   localparam int CL       = CORDIC_STEPS + 6;
   localparam int DL       = QB + 2;
   localparam int LAST     = CL + DL + 6;
   localparam int SPLIT    = 17;
   localparam int PH_W     = Q_W - SPLIT + 31;
   localparam int PL_W     = SPLIT + 30;
   localparam int PROD_W   = 66;
   localparam int COORD_SH = 46 - COORD_FRAC_BITS;
   localparam int X_W      = PROD_W - COORD_SH;
   localparam int DX_W     = X_W + 1;
   localparam int IDX_W    = DX_W - COORD_FRAC_BITS + 2;
   localparam logic signed [31:0] SCALE_S = 32'(SCALE_Q16);
   localparam logic signed [DX_W-1:0] ROUND_UP = DX_W'((64'd1 << COORD_FRAC_BITS) - 64'd1);

   // configuration registers
   logic [11:0]        grid_cols_ff, grid_rows_ff, offset_col_ff, offset_row_ff;
   logic signed [23:0] origin_x_ff, origin_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff  <= 12'd900;
         grid_rows_ff  <= 12'd900;
         offset_col_ff <= 12'd450;
         offset_row_ff <= 12'd450;
         origin_x_ff   <= -24'sd75225;
         origin_y_ff   <= -24'sd4309647;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_COLS:  grid_cols_ff  <= csr_wdata[11:0];
            CSR_GRID_ROWS:  grid_rows_ff  <= csr_wdata[11:0];
            CSR_OFFSET_COL: offset_col_ff <= csr_wdata[11:0];
            CSR_OFFSET_ROW: offset_row_ff <= csr_wdata[11:0];
            CSR_ORIGIN_X:   origin_x_ff   <= $signed(csr_wdata);
            CSR_ORIGIN_Y:   origin_y_ff   <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // global advance: hold everything while the output register is blocked
   logic            en;
   logic [LAST:0]   vld_ff;

   assign en        = !(vld_ff[LAST] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset)   vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[LAST-1:0], req_valid};
   end

   // input stage
   logic signed [ANG_W-1:0] dlon_ff, lat_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dlon_ff <= ANG_W'(req_longitude) - REF_MERIDIAN;
         lat_ff  <= ANG_W'(req_latitude);
      end
   end

   logic signed [XY_W-1:0] sin_lat, cos_lat, sin_lon, cos_lon;

   lpsg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_lat (
      .clock   (clock),
      .en      (en),
      .angle   (lat_ff),
      .sin_out (sin_lat),
      .cos_out (cos_lat)
   );

   lpsg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_lon (
      .clock   (clock),
      .en      (en),
      .angle   (dlon_ff),
      .sin_out (sin_lon),
      .cos_out (cos_lon)
   );

   // numerators and denominator of the ratio
   logic signed [2*XY_W-1:0] pnx, pny;
   logic signed [XY_W:0]     den_sum;
   logic signed [NUM_W-1:0]  numx_ff, numy_ff;
   logic [DEN_W-1:0]         den_ff;

   assign pnx     = cos_lat * sin_lon;
   assign pny     = cos_lat * cos_lon;
   assign den_sum = (XY_W+1)'(sin_lat) + $signed((XY_W+1)'(64'd1 << RATIO_FRAC));

   always_ff @(posedge clock) begin
      if (en) begin
         numx_ff <= NUM_W'(pnx >>> RATIO_FRAC);
         numy_ff <= NUM_W'(pny >>> RATIO_FRAC);
         den_ff  <= (den_sum < $signed((XY_W+1)'(1))) ? DEN_W'(1) : DEN_W'(den_sum);
      end
   end

   logic signed [Q_W-1:0] qx, qy;

   lpsg_div u_div_x (
      .clock (clock),
      .en    (en),
      .num   (numx_ff),
      .den   (den_ff),
      .quot  (qx)
   );

   lpsg_div u_div_y (
      .clock (clock),
      .en    (en),
      .num   (numy_ff),
      .den   (den_ff),
      .quot  (qy)
   );

   // scale by R*(1+sin60) in two partial products
   logic signed [Q_W-SPLIT-1:0] hix, hiy;
   logic signed [PH_W-1:0]      phx_ff, phy_ff;
   logic [PL_W-1:0]             plx_ff, ply_ff;

   assign hix = (Q_W-SPLIT)'(qx >>> SPLIT);
   assign hiy = (Q_W-SPLIT)'(qy >>> SPLIT);

   always_ff @(posedge clock) begin
      if (en) begin
         phx_ff <= PH_W'(hix) * PH_W'(SCALE_S);
         phy_ff <= PH_W'(hiy) * PH_W'(SCALE_S);
         plx_ff <= PL_W'(qx[SPLIT-1:0]) * PL_W'(SCALE_Q16);
         ply_ff <= PL_W'(qy[SPLIT-1:0]) * PL_W'(SCALE_Q16);
      end
   end

   logic signed [PROD_W-1:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= (PROD_W'(phx_ff) <<< SPLIT) + $signed(PROD_W'(plx_ff));
         py_ff <= (PROD_W'(phy_ff) <<< SPLIT) + $signed(PROD_W'(ply_ff));
      end
   end

   // km coordinates relative to the grid origin
   logic signed [PROD_W-1:0] npy;
   logic signed [X_W-1:0]    xk, yk;
   logic signed [DX_W-1:0]   dx_ff, dy_ff;

   assign npy = -py_ff;
   assign xk  = X_W'(px_ff >>> COORD_SH);
   assign yk  = X_W'(npy >>> COORD_SH);

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= DX_W'(xk) - DX_W'(origin_x_ff);
         dy_ff <= DX_W'(yk) - DX_W'(origin_y_ff);
      end
   end

   // quadrant floor/ceil cell rules
   logic signed [IDX_W-1:0] fx, cx, fy, cy, oc, orw, col_in, row_in;
   logic signed [IDX_W-1:0] col_ff, row_ff;

   always_comb begin
      fx  = IDX_W'(dx_ff >>> COORD_FRAC_BITS);
      cx  = IDX_W'((dx_ff + ROUND_UP) >>> COORD_FRAC_BITS);
      fy  = IDX_W'(dy_ff >>> COORD_FRAC_BITS);
      cy  = IDX_W'((dy_ff + ROUND_UP) >>> COORD_FRAC_BITS);
      oc  = $signed(IDX_W'(offset_col_ff));
      orw = $signed(IDX_W'(offset_row_ff));
      if (dx_ff[DX_W-1])       col_in = fx + oc;
      else if (!dy_ff[DX_W-1]) col_in = cx + oc - IDX_W'(1);
      else                     col_in = fx + oc - IDX_W'(1);
      if (dy_ff[DX_W-1])       row_in = fy + orw;
      else                     row_in = cy + orw - IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // output register: saturate and test against the grid
   localparam logic signed [IDX_W-1:0] S16_MAX = IDX_W'(32767);
   localparam logic signed [IDX_W-1:0] S16_MIN = -IDX_W'(32768);

   logic signed [15:0] col_out_ff, row_out_ff;
   logic               inside_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         col_out_ff <= (col_ff > S16_MAX) ? 16'sh7fff :
                       (col_ff < S16_MIN) ? 16'sh8000 : 16'(col_ff);
         row_out_ff <= (row_ff > S16_MAX) ? 16'sh7fff :
                       (row_ff < S16_MIN) ? 16'sh8000 : 16'(row_ff);
         inside_ff  <= !col_ff[IDX_W-1] && !row_ff[IDX_W-1] &&
                       (col_ff < $signed(IDX_W'(grid_cols_ff))) &&
                       (row_ff < $signed(IDX_W'(grid_rows_ff)));
      end
   end

   assign rsp_col        = col_out_ff;
   assign rsp_row        = row_out_ff;
   assign rsp_inside_res = inside_ff;

endmodule

@@ rtl/lpsg_cordic.sv @@
// One angle lane: wrap and fold to +-90 deg, convert to radians, pipelined CORDIC rotation.
// Depends on lpsg_pkg. Takes one angle per cycle while en is high.
module lpsg_cordic
   import lpsg_pkg::*;
#(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [ANG_W-1:0] angle,
   output logic signed [XY_W-1:0]  sin_out,
   output logic signed [XY_W-1:0]  cos_out
);

   localparam logic signed [ANG_W-1:0] HALF_A = ANG_W'(HALF_TURN);
   localparam logic signed [ANG_W-1:0] FULL_A = ANG_W'(FULL_TURN);
   localparam logic signed [RED_W+1:0] HALF_R = (RED_W+2)'(HALF_TURN);
   localparam logic signed [RED_W+1:0] QUART_R = (RED_W+2)'(QUARTER_TURN);
   localparam int P_W = MAG_W + 32;
   localparam int B_W = QE_W + HALF_W;
   localparam int R_W = P_W + 3;

   // wrap
   logic signed [ANG_W-1:0] wrap_in;
   logic signed [RED_W-1:0] red_ff;

   always_comb begin
      if (angle >= HALF_A)       wrap_in = angle - FULL_A;
      else if (angle < -HALF_A)  wrap_in = angle + FULL_A;
      else                       wrap_in = angle;
   end

   always_ff @(posedge clock) begin
      if (en) red_ff <= RED_W'(wrap_in);
   end

   // fold into [-90, 90]; cosine flips sign
   logic signed [RED_W+1:0] fold_in;
   logic                    flip_in;
   logic [MAG_W-1:0]        mag_ff;
   logic                    neg2_ff, flip2_ff;

   always_comb begin
      flip_in = 1'b0;
      fold_in = (RED_W+2)'(red_ff);
      if ((RED_W+2)'(red_ff) > QUART_R) begin
         fold_in = HALF_R - (RED_W+2)'(red_ff);
         flip_in = 1'b1;
      end else if ((RED_W+2)'(red_ff) < -QUART_R) begin
         fold_in = -HALF_R - (RED_W+2)'(red_ff);
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= fold_in[RED_W+1] ? MAG_W'(-fold_in) : MAG_W'(fold_in);
         neg2_ff  <= fold_in[RED_W+1];
         flip2_ff <= flip_in;
      end
   end

   // exact product and reciprocal estimate of the quotient
   logic [P_W-1:0]  prod3_ff;
   logic [QE_W-1:0] est3_ff;
   logic [P_W-1:0]  est_full;
   logic            neg3_ff, flip3_ff;

   assign est_full = P_W'(mag_ff) * P_W'(RECIP);

   always_ff @(posedge clock) begin
      if (en) begin
         prod3_ff <= P_W'(mag_ff) * P_W'(PI_Q30);
         est3_ff  <= QE_W'(est_full >> RECIP_SH);
         neg3_ff  <= neg2_ff;
         flip3_ff <= flip2_ff;
      end
   end

   logic [B_W-1:0]  back4_ff;
   logic [P_W-1:0]  prod4_ff;
   logic [QE_W-1:0] est4_ff;
   logic            neg4_ff, flip4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         back4_ff <= B_W'(est3_ff) * B_W'(HALF_TURN);
         prod4_ff <= prod3_ff;
         est4_ff  <= est3_ff;
         neg4_ff  <= neg3_ff;
         flip4_ff <= flip3_ff;
      end
   end

   // estimate is exact or one high
   logic signed [R_W-1:0] rem;
   logic [QE_W-1:0]       zq;
   logic signed [Z_W-1:0] z_in;

   always_comb begin
      rem  = $signed(R_W'(prod4_ff)) - $signed(R_W'(back4_ff));
      zq   = rem[R_W-1] ? est4_ff - QE_W'(1) : est4_ff;
      z_in = neg4_ff ? -$signed(Z_W'(zq)) : $signed(Z_W'(zq));
   end

   logic signed [XY_W-1:0] x_ff [0:STEPS];
   logic signed [XY_W-1:0] y_ff [0:STEPS];
   logic signed [Z_W-1:0]  z_ff [0:STEPS];
   logic                   fl_ff [0:STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]  <= XY_W'(GAIN_Q30);
         y_ff[0]  <= '0;
         z_ff[0]  <= z_in;
         fl_ff[0] <= flip4_ff;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [Z_W-1:0] ATAN_I = atan_q30(i);
      logic signed [XY_W-1:0] xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][Z_W-1]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - ATAN_I;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + ATAN_I;
            end
            fl_ff[i+1] <= fl_ff[i];
         end
      end
   end

   logic signed [XY_W-1:0] sin_ff, cos_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= y_ff[STEPS];
         cos_ff <= fl_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

@@ rtl/lpsg_div.sv @@
// Pipelined restoring divider: num * 2^30 / den, truncated toward zero, clamped to +-2^33.
// Depends on lpsg_pkg. One quotient bit per stage.
module lpsg_div
   import lpsg_pkg::*;
(
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic signed [Q_W-1:0]   quot
);

   localparam int EXTRA = QB - RATIO_FRAC;
   localparam logic [QB-1:0] LIM = QB'(RATIO_LIM);

   logic [NUM_W-1:0] mag;
   logic [NUM_W-1:0] hi;
   logic             ovf_in;

   assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign hi     = mag >> EXTRA;
   assign ovf_in = (DEN_W+1)'(hi) >= (DEN_W+1)'(den);

   logic [DEN_W-1:0] rem_ff [0:QB];
   logic [QB-1:0]    low_ff [0:QB];
   logic [QB-1:0]    q_ff   [0:QB];
   logic [DEN_W-1:0] den_ff [0:QB];
   logic             ovf_ff [0:QB];
   logic             sgn_ff [0:QB];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= ovf_in ? '0 : DEN_W'(hi);
         low_ff[0] <= {mag[EXTRA-1:0], {RATIO_FRAC{1'b0}}};
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         ovf_ff[0] <= ovf_in;
         sgn_ff[0] <= num[NUM_W-1];
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_bit
      logic [DEN_W:0] r2;
      logic           take;
      assign r2   = {rem_ff[k], low_ff[k][QB-1]};
      assign take = r2 >= {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= take ? DEN_W'(r2 - {1'b0, den_ff[k]}) : DEN_W'(r2);
            low_ff[k+1] <= low_ff[k] << 1;
            q_ff[k+1]   <= {q_ff[k][QB-2:0], take};
            den_ff[k+1] <= den_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            sgn_ff[k+1] <= sgn_ff[k];
         end
      end
   end

   logic [QB-1:0]         qm;
   logic signed [Q_W-1:0] quot_ff;

   assign qm = (ovf_ff[QB] || q_ff[QB] > LIM) ? LIM : q_ff[QB];

   always_ff @(posedge clock) begin
      if (en) quot_ff <= sgn_ff[QB] ? -$signed(Q_W'(qm)) : $signed(Q_W'(qm));
   end

   assign quot = quot_ff;

endmodule

@@ tb/sv/lpsg_grid_checker.sv @@
// Checker for the polar stereographic grid mapper: watches the request, response
// and register channels, predicts each grid cell and compares in transfer order.
// Depends on lpsg_pkg for the field widths and register indexes.
module lpsg_grid_checker
   import lpsg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic signed [LON_W-1:0] req_longitude,
   input  logic signed [LAT_W-1:0] req_latitude,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [15:0]      rsp_col,
   input  logic signed [15:0]      rsp_row,
   input  logic                    rsp_inside_res,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [23:0]             csr_wdata,
   output int                      errors,
   output int                      pending
);

   typedef struct {
      logic signed [15:0] col;
      logic signed [15:0] row;
      logic               in_grid;
   } cell_type;

   localparam int     STEPS    = CORDIC_STEPS_DEF;
   localparam longint SCALE    = 779003918;
   localparam longint ONE_Q30  = 64'sd1 << 30;
   localparam longint LIM      = 64'sd1 << 33;

   longint pi_q30;
   longint atan_tab [32];

   logic [11:0] cols_r, rows_r, offc_r, offr_r;
   longint      orgx_r, orgy_r;
   cell_type    cell_q [$];
   int          err_cnt = 0;

   assign errors = err_cnt;

   // atan(1/n) Q62 by truncated alternating series
   function automatic longint unsigned atan_inv(input longint unsigned n);
      longint unsigned s, p, t, k;
      s = 0; p = (64'd1 << 62) / n; k = 0;
      while (p != 0) begin
         t = p / (2 * k + 1);
         if (k[0]) s = s - t; else s = s + t;
         p = p / (n * n);
         k++;
      end
      return s;
   endfunction

   initial begin
      longint unsigned q;
      q = atan_inv(2) + atan_inv(3);
      pi_q30 = longint'((q + (64'd1 << 29)) >> 30);
      atan_tab[0] = longint'((q + (64'd1 << 31)) >> 32);
      for (int i = 1; i < 32; i++)
         atan_tab[i] = longint'((atan_inv(64'd1 << i) + (64'd1 << 31)) >> 32);
   end

   task automatic sin_cos(input longint a, output longint sv, output longint cv);
      longint full, half, quarter, r, x, y, z, xs, ys;
      bit     flip;
      full = 360 << 16; half = 180 << 16; quarter = 90 << 16;
      r = a % full; flip = 0;
      if (r >= half) r -= full;
      if (r < -half) r += full;
      if (r > quarter) begin
         r = half - r; flip = 1;
      end else if (r < -quarter) begin
         r = -half - r; flip = 1;
      end
      z = r * pi_q30 / half;
      x = 652032874; y = 0;
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i; ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= atan_tab[i];
         end else begin
            x += ys; y -= xs; z += atan_tab[i];
         end
      end
      sv = y;
      cv = flip ? -x : x;
   endtask

   function automatic longint clamp_ratio(input longint num, input longint den);
      longint q;
      q = num * ONE_Q30 / den;
      if (q > LIM) q = LIM;
      if (q < -LIM) q = -LIM;
      return q;
   endfunction

   function automatic logic signed [15:0] sat16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   task automatic project_to_cell(input longint lon, input longint lat, output cell_type c);
      longint sl, cl, sd, cd, den, qx, qy, x, y, dx, dy, col, row;
      sin_cos(lat, sl, cl);
      sin_cos(lon - (10 << 16), sd, cd);
      den = ONE_Q30 + sl;
      if (den < 1) den = 1;
      qx = clamp_ratio((cl * sd) >>> 30, den);
      qy = clamp_ratio((cl * cd) >>> 30, den);
      x = (qx * SCALE) >>> 36;
      y = (-(qy * SCALE)) >>> 36;
      dx = x - orgx_r;
      dy = y - orgy_r;
      if (dx < 0) col = (dx >>> 10) + longint'(offc_r);
      else if (dy >= 0) col = ((dx + 1023) >>> 10) + longint'(offc_r) - 1;
      else col = (dx >>> 10) + longint'(offc_r) - 1;
      if (dy < 0) row = (dy >>> 10) + longint'(offr_r);
      else row = ((dy + 1023) >>> 10) + longint'(offr_r) - 1;
      c.col = sat16(col);
      c.row = sat16(row);
      c.in_grid = col >= 0 && row >= 0 && col < longint'(cols_r) && row < longint'(rows_r);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      err_cnt++;
   endtask

   always @(posedge clock) begin
      cell_type c, want;
      if (reset) begin
         cols_r <= 12'd900; rows_r <= 12'd900;
         offc_r <= 12'd450; offr_r <= 12'd450;
         orgx_r <= -75225;  orgy_r <= -4309647;
         cell_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_COLS:  cols_r <= csr_wdata[11:0];
               CSR_GRID_ROWS:  rows_r <= csr_wdata[11:0];
               CSR_OFFSET_COL: offc_r <= csr_wdata[11:0];
               CSR_OFFSET_ROW: offr_r <= csr_wdata[11:0];
               CSR_ORIGIN_X:   orgx_r <= longint'(signed'(csr_wdata));
               CSR_ORIGIN_Y:   orgy_r <= longint'(signed'(csr_wdata));
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            project_to_cell(longint'(req_longitude), longint'(req_latitude), c);
            cell_q.push_back(c);
         end
         if (rsp_valid && !rsp_stall) begin
            if (cell_q.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = cell_q.pop_front();
               if (rsp_col !== want.col) report_mismatch("col", rsp_col, want.col);
               if (rsp_row !== want.row) report_mismatch("row", rsp_row, want.row);
               if (rsp_inside_res !== want.in_grid)
                  report_mismatch("inside_res", rsp_inside_res, want.in_grid);
            end
         end
      end
      pending <= cell_q.size();
   end

endmodule

@@ tb/sv/latlon_to_polar_stereo_grid_top_test.sv @@
// Top of the grid mapper testbench: clock, reset, stimulus and verdict.
// Depends on lpsg_pkg, the block and lpsg_grid_checker.
module latlon_to_polar_stereo_grid_top_test
   import lpsg_pkg::*;
();

   localparam logic [2:0] IDX_NONE = 3'd7;
   localparam int LON_MAX = 11796480;
   localparam int LAT_MAX = 5898240;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [LON_W-1:0] req_longitude = '0;
   logic signed [LAT_W-1:0] req_latitude = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [15:0]      rsp_col, rsp_row;
   logic                    rsp_inside_res;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [2:0]              csr_index = '0;
   logic [23:0]             csr_wdata = '0;

   int errors, pending;
   int tx_pct = 0, rx_pct = 0;
   int hold_len = 0;
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   int items_sent = 0;

   latlon_to_polar_stereo_grid_top u_dut (.*);

   lpsg_grid_checker u_chk (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_len  <= 399;
         rsp_stall <= 1'b1;
      end else if (hold_len > 0) begin
         hold_len  <= hold_len - 1;
         rsp_stall <= 1'b1;
      end else rsp_stall <= ($urandom_range(99) < rx_pct);
   end

   task automatic send_point(input int lon, input int lat);
      while ($urandom_range(99) < tx_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_longitude <= LON_W'(lon);
      req_latitude  <= LAT_W'(lat);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 24'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (90) @(posedge clock);
   endtask

   task automatic load_grid(input int cols, input int rows, input int offc, input int offr,
                            input int orgx, input int orgy);
      csr_write(CSR_GRID_COLS, cols);
      csr_write(CSR_GRID_ROWS, rows);
      csr_write(CSR_OFFSET_COL, offc);
      csr_write(CSR_OFFSET_ROW, offr);
      csr_write(CSR_ORIGIN_X, orgx);
      csr_write(CSR_ORIGIN_Y, orgy);
      csr_write(IDX_NONE, $urandom);   // unmapped index, must be ignored
      csr_valid <= 1'b0;
   endtask

   task automatic random_points(input int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         if (items_sent > 830) begin
            tx_pct = 0; rx_pct = 0;
         end else if (items_sent > 430) begin
            tx_pct = 85; rx_pct = 22;
         end
         sel = $urandom_range(9);
         if (sel < 6)       // mostly around the grid area
            send_point($urandom_range(0, 25 << 16) - (3 << 16),
                       $urandom_range(44 << 16, 62 << 16));
         else if (sel < 8)
            send_point($urandom_range(0, 2 * LON_MAX) - LON_MAX,
                       $urandom_range(0, 2 * LAT_MAX) - LAT_MAX);
         else
            send_point($urandom, $urandom);   // raw bit patterns, wrap cases
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      tx_pct = 22; rx_pct = 85;
      @(posedge clock);

      // directed: field extremes, poles, meridian, points near the origin quadrants
      send_point(LON_MAX, LAT_MAX);
      send_point(-LON_MAX, -LAT_MAX);
      send_point(0, -LAT_MAX);
      send_point(10 << 16, LAT_MAX);
      send_point(10 << 16, 0);
      send_point(9 << 16, 51 << 16);
      send_point((9 << 16) + 20, (51 << 16) + 20);
      send_point((9 << 16) - 20, (51 << 16) + 20);
      send_point((9 << 16) + 20, (51 << 16) - 20);
      send_point((9 << 16) - 20, (51 << 16) - 20);
      send_point(25'sh0ffffff, 24'sh7fffff);
      send_point(25'sh1000000, 24'sh800000);
      send_point(190 << 16, 95 << 16);
      send_point(-(200 << 16), -(100 << 16));
      send_point(170 << 16, -(89 << 16));
      send_point(15 << 16, 60 << 16);
      send_point(-1, -1);
      drain();

      random_points(300);
      drain();
      load_grid(1400, 1500, 600, 800, -75225, -4309647);
      random_points(300);
      drain();
      load_grid(4095, 4095, 0, 0, -8388608, 8388607);
      random_points(150);
      drain();
      load_grid(1, 1, 4095, 4095, 8388607, -8388608);
      random_points(150);
      drain();
      load_grid(900, 900, 450, 450, -75225, -4309647);
      hold_req = 1'b1;         // long receiver hold-off while items keep coming
      random_points(350);
      drain();

      $display("covered %0d points over five grid settings, poles, wrapped angles,",
               items_sent);
      $display("sender and receiver idling phases and one long receiver hold-off");
      if (errors == 0) $display("PASS latlon_to_polar_stereo_grid_top");
      else $display("FAIL latlon_to_polar_stereo_grid_top");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("FAIL latlon_to_polar_stereo_grid_top");
      $finish;
   end

endmodule
